// ===== hw/rtl/sbo_pkg.sv =====
// ----------------------------------------------------------------------------
// sbo_pkg
// Shared widths, reset values and stage bundles of the selection/block
// overlap pipeline.
// ----------------------------------------------------------------------------
package sbo_pkg;

    localparam int DATA_W       = 64;   // index, extent and product width
    localparam int HALF_W       = 32;   // product halves
    localparam int ELEM_W       = 5;    // element size register
    localparam int DIM_IDX_W    = 4;    // reported dimension index
    localparam int MAX_DIMS_DEF = 16;

    localparam logic [ELEM_W-1:0] ELEM_BYTES_RST = ELEM_W'(1);

    // Compare results of the first stage, used by the second stage
    typedef struct packed {
        logic              flag;      // this dimension overlaps
        logic              oob;       // this dimension exceeds global size
        logic              s_ge_o;    // sel_start >= block_offset
        logic              s_lt_eb;   // sel_start < block end
        logic              eb_lt_es;  // block end < selection end
        logic              o_lt_es;   // block_offset < selection end
        logic [DATA_W-1:0] es_lo;     // selection end, low bits
        logic [DATA_W-1:0] eb_lo;     // block end, low bits
    } t_cmp;

    // Pipeline controls seen by the product unit
    typedef struct packed {
        logic cfg_we;
        logic s1_go;
        logic s1_last;
        logic s2_go;
        logic s2_last;
    } t_prod_ctl;

endpackage

// ===== hw/rtl/selection_block_overlap.sv =====
// ----------------------------------------------------------------------------
// selection_block_overlap
// Intersects a rectangular selection with one stored block, one dimension
// per transfer, and reports overlap, offsets and running block statistics.
// ----------------------------------------------------------------------------
// Each input transfer carries one dimension (selection start/count, block
// size, global size, block offset, last flag) and produces exactly one result
// transfer: the overlap length in that dimension and where it starts inside
// the block and inside the selection, all zero when there is no overlap. With
// every result come the dimension index, a running AND of the overlap flags,
// a sticky out-of-bound flag and the payload byte count (element size times
// the block sizes so far, wrapping mod 2^64; meaningless once out_of_bound is
// set). The result of a last-dimension item clears the running state. The
// pipeline takes one dimension per cycle while no stage holds, through the
// input register, compare stage and select stage into the result register.
// The 64-bit product is formed as 32-bit halves, low half in the compare
// stage and high half in the select stage, which keeps the running product
// at one item per cycle. A stage holds only if the next is full and holding,
// so a waiting result does not block earlier stages with room. The user must
// write element_bytes via i_cfg_wr_en / i_cfg_wr_data only while the pipeline
// is empty, unchecked by the block; a write restarts the payload product.
// ----------------------------------------------------------------------------
module selection_block_overlap #(
    parameter int MAX_DIMS = sbo_pkg::MAX_DIMS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_wr_en,
    input  logic [sbo_pkg::ELEM_W-1:0]          i_cfg_wr_data,
    // input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [sbo_pkg::DATA_W-1:0]          i_sel_start,
    input  logic [sbo_pkg::DATA_W-1:0]          i_sel_count,
    input  logic [sbo_pkg::DATA_W-1:0]          i_block_size,
    input  logic [sbo_pkg::DATA_W-1:0]          i_global_size,
    input  logic [sbo_pkg::DATA_W-1:0]          i_block_offset,
    input  logic                                i_last_dim,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [sbo_pkg::DATA_W-1:0]          o_part_size,
    output logic [sbo_pkg::DATA_W-1:0]          o_part_offset_in_block,
    output logic [sbo_pkg::DATA_W-1:0]          o_part_offset_in_selection,
    output logic [sbo_pkg::DIM_IDX_W-1:0]       o_dim_index,
    output logic                                o_is_last,
    output logic                                o_block_useful,
    output logic                                o_out_of_bound,
    output logic [sbo_pkg::DATA_W-1:0]          o_payload_bytes
);

    localparam int DW   = sbo_pkg::DATA_W;
    localparam int IW   = sbo_pkg::DIM_IDX_W;
    // dimension counter width, at least one bit
    localparam int DimW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    // ---- pipeline occupancy and flow ----
    logic r_v1, r_v2, r_v3;
    logic rdy2, rdy3;
    logic in_xfer, out_xfer, go1, go2;

    assign rdy3     = !r_v3 || i_ready;
    assign rdy2     = !r_v2 || rdy3;
    assign o_ready  = i_rst_n && (!r_v1 || rdy2);
    assign in_xfer  = i_valid && o_ready;
    assign go1      = r_v1 && rdy2;       // input register -> compare regs
    assign go2      = r_v2 && rdy3;       // compare regs -> result register
    assign o_valid  = r_v3;
    assign out_xfer = r_v3 && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_v1 <= 1'b1;
            end else if (go1) begin
                r_v1 <= 1'b0;
            end
            if (go1) begin
                r_v2 <= 1'b1;
            end else if (go2) begin
                r_v2 <= 1'b0;
            end
            if (go2) begin
                r_v3 <= 1'b1;
            end else if (out_xfer) begin
                r_v3 <= 1'b0;
            end
        end
    end

    // ---- stage 1: input register ----
    logic [DW-1:0] r_s1_start, r_s1_count, r_s1_bsize, r_s1_global, r_s1_offset;
    logic          r_s1_last;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_start  <= i_sel_start;
            r_s1_count  <= i_sel_count;
            r_s1_bsize  <= i_block_size;
            r_s1_global <= i_global_size;
            r_s1_offset <= i_block_offset;
            r_s1_last   <= i_last_dim;
        end
    end

    sbo_pkg::t_cmp s1_cmp;

    sbo_cmp u_cmp (
        .i_start  (r_s1_start),
        .i_count  (r_s1_count),
        .i_size   (r_s1_bsize),
        .i_global (r_s1_global),
        .i_offset (r_s1_offset),
        .o_cmp    (s1_cmp)
    );

    // running per-selection state, advanced as an item leaves stage 1
    logic            r_useful;
    logic            r_bound;
    logic [DimW-1:0] r_dim_cnt;
    logic            n_useful;
    logic            n_bound;
    logic [DimW-1:0] n_dim_cnt;

    assign n_useful  = r_useful && s1_cmp.flag;
    assign n_bound   = r_bound || s1_cmp.oob;
    assign n_dim_cnt = (r_dim_cnt == DimW'(MAX_DIMS - 1)) ? '0 : r_dim_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_useful  <= 1'b1;
            r_bound   <= 1'b0;
            r_dim_cnt <= '0;
        end else if (go1) begin
            if (r_s1_last) begin
                r_useful  <= 1'b1;
                r_bound   <= 1'b0;
                r_dim_cnt <= '0;
            end else begin
                r_useful  <= n_useful;
                r_bound   <= n_bound;
                r_dim_cnt <= n_dim_cnt;
            end
        end
    end

    // low bits of the counter as the reported index (zero-padded if narrow)
    logic [DimW+IW-1:0] dim_ext;
    assign dim_ext = {{IW{1'b0}}, r_dim_cnt};

    // ---- stage 2: compare registers ----
    sbo_pkg::t_cmp r_s2_cmp;
    logic [DW-1:0] r_s2_start, r_s2_count, r_s2_bsize, r_s2_offset;
    logic [IW-1:0] r_s2_dim;
    logic          r_s2_last, r_s2_useful, r_s2_oob;

    always_ff @(posedge i_clk) begin
        if (go1) begin
            r_s2_cmp    <= s1_cmp;
            r_s2_start  <= r_s1_start;
            r_s2_count  <= r_s1_count;
            r_s2_bsize  <= r_s1_bsize;
            r_s2_offset <= r_s1_offset;
            r_s2_dim    <= dim_ext[IW-1:0];
            r_s2_last   <= r_s1_last;
            r_s2_useful <= n_useful;
            r_s2_oob    <= n_bound;
        end
    end

    logic [DW-1:0] s2_size, s2_off_blk, s2_off_sel;

    sbo_part u_part (
        .i_cmp       (r_s2_cmp),
        .i_start     (r_s2_start),
        .i_count     (r_s2_count),
        .i_size      (r_s2_bsize),
        .i_offset    (r_s2_offset),
        .o_part_size (s2_size),
        .o_off_blk   (s2_off_blk),
        .o_off_sel   (s2_off_sel)
    );

    // payload product spans stages 1 and 2
    sbo_pkg::t_prod_ctl prod_ctl;
    logic [DW-1:0]      s2_prod;

    always_comb begin
        prod_ctl.cfg_we  = i_cfg_wr_en;
        prod_ctl.s1_go   = go1;
        prod_ctl.s1_last = r_s1_last;
        prod_ctl.s2_go   = go2;
        prod_ctl.s2_last = r_s2_last;
    end

    sbo_prod u_prod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (prod_ctl),
        .i_cfg_data (i_cfg_wr_data),
        .i_factor   (r_s1_bsize),
        .o_prod     (s2_prod)
    );

    // ---- stage 3: result register ----
    logic [DW-1:0] r_o_size, r_o_off_blk, r_o_off_sel, r_o_prod;
    logic [IW-1:0] r_o_dim;
    logic          r_o_last, r_o_useful, r_o_oob;

    always_ff @(posedge i_clk) begin
        if (go2) begin
            r_o_size    <= s2_size;
            r_o_off_blk <= s2_off_blk;
            r_o_off_sel <= s2_off_sel;
            r_o_prod    <= s2_prod;
            r_o_dim     <= r_s2_dim;
            r_o_last    <= r_s2_last;
            r_o_useful  <= r_s2_useful;
            r_o_oob     <= r_s2_oob;
        end
    end

    assign o_part_size                = r_o_size;
    assign o_part_offset_in_block     = r_o_off_blk;
    assign o_part_offset_in_selection = r_o_off_sel;
    assign o_payload_bytes            = r_o_prod;
    assign o_dim_index                = r_o_dim;
    assign o_is_last                  = r_o_last;
    assign o_block_useful             = r_o_useful;
    assign o_out_of_bound             = r_o_oob;

    // ---- assertions ----

    // input held off only when every stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled with a free pipeline stage");

    // a last dimension leaving stage 1 restarts the running state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go1 && r_s1_last) |=> (r_dim_cnt == '0 && r_useful && !r_bound))
        else $error("running state not cleared after last dimension");

    // no overlap means zero offsets
    a_zero_offsets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_part_size == '0) |->
            (o_part_offset_in_block == '0 && o_part_offset_in_selection == '0))
        else $error("nonzero offset with empty overlap");

    // a result register that is being refilled must be empty or draining
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go2 && r_v3) |-> i_ready)
        else $error("result overwritten before transfer");

endmodule

// ===== hw/rtl/sbo_cmp.sv =====
// ----------------------------------------------------------------------------
// sbo_cmp
// First stage: exact 65-bit ends, overlap flag and bound check of one
// dimension.
// ----------------------------------------------------------------------------
module sbo_cmp (
    input  logic [sbo_pkg::DATA_W-1:0] i_start,
    input  logic [sbo_pkg::DATA_W-1:0] i_count,
    input  logic [sbo_pkg::DATA_W-1:0] i_size,
    input  logic [sbo_pkg::DATA_W-1:0] i_global,
    input  logic [sbo_pkg::DATA_W-1:0] i_offset,
    output sbo_pkg::t_cmp              o_cmp
);

    logic [sbo_pkg::DATA_W:0] es;
    logic [sbo_pkg::DATA_W:0] eb;
    logic [sbo_pkg::DATA_W:0] s_w;
    logic [sbo_pkg::DATA_W:0] o_w;
    logic [sbo_pkg::DATA_W:0] g_w;
    logic                     o_ge_s;
    logic                     es_lt_eb;

    assign s_w = {1'b0, i_start};
    assign o_w = {1'b0, i_offset};
    assign g_w = {1'b0, i_global};
    assign es  = s_w + {1'b0, i_count};
    assign eb  = o_w + {1'b0, i_size};

    assign o_ge_s   = (i_offset >= i_start);
    assign es_lt_eb = (es < eb);

    always_comb begin
        o_cmp.s_ge_o   = (i_start >= i_offset);
        o_cmp.s_lt_eb  = (s_w < eb);
        o_cmp.eb_lt_es = (eb < es);
        o_cmp.o_lt_es  = (o_w < es);
        o_cmp.es_lo    = es[sbo_pkg::DATA_W-1:0];
        o_cmp.eb_lo    = eb[sbo_pkg::DATA_W-1:0];
        o_cmp.oob      = (i_count > i_global) || (i_start > i_global) || (g_w < es);
        o_cmp.flag     = (o_ge_s && o_cmp.o_lt_es) ||
                         (!o_ge_s && es_lt_eb) ||
                         (o_cmp.s_lt_eb && !es_lt_eb);
    end

endmodule

// ===== hw/rtl/sbo_part.sv =====
// ----------------------------------------------------------------------------
// sbo_part
// Second stage: overlap length and its offsets in block and selection.
// ----------------------------------------------------------------------------
module sbo_part (
    input  sbo_pkg::t_cmp              i_cmp,
    input  logic [sbo_pkg::DATA_W-1:0] i_start,
    input  logic [sbo_pkg::DATA_W-1:0] i_count,
    input  logic [sbo_pkg::DATA_W-1:0] i_size,
    input  logic [sbo_pkg::DATA_W-1:0] i_offset,
    output logic [sbo_pkg::DATA_W-1:0] o_part_size,
    output logic [sbo_pkg::DATA_W-1:0] o_off_blk,
    output logic [sbo_pkg::DATA_W-1:0] o_off_sel
);

    logic [sbo_pkg::DATA_W-1:0] size;
    logic [sbo_pkg::DATA_W-1:0] off_blk;
    logic [sbo_pkg::DATA_W-1:0] off_sel;

    always_comb begin
        size    = '0;
        off_blk = '0;
        off_sel = '0;
        if (i_cmp.s_ge_o) begin
            if (i_cmp.s_lt_eb) begin
                // block end lies past the start, so the differences fit
                size    = i_cmp.eb_lt_es ? (i_cmp.eb_lo - i_start) : i_count;
                off_blk = i_start - i_offset;
            end
        end else begin
            if (i_cmp.eb_lt_es) begin
                size = i_size;
            end else if (i_cmp.o_lt_es) begin
                // count - (offset - start) is the selection end minus offset
                size = i_cmp.es_lo - i_offset;
            end
            off_sel = i_offset - i_start;
        end
    end

    // no overlap reports all zeros
    assign o_part_size = size;
    assign o_off_blk   = (size == '0) ? '0 : off_blk;
    assign o_off_sel   = (size == '0) ? '0 : off_sel;

endmodule

// ===== hw/rtl/sbo_prod.sv =====
// ----------------------------------------------------------------------------
// sbo_prod
// Running payload product, mod 2^64, split in 32-bit halves over two
// stages: low half and one cross term first, high half in the second.
// ----------------------------------------------------------------------------
module sbo_prod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sbo_pkg::t_prod_ctl          i_ctl,
    input  logic [sbo_pkg::ELEM_W-1:0]  i_cfg_data,
    input  logic [sbo_pkg::DATA_W-1:0]  i_factor,
    output logic [sbo_pkg::DATA_W-1:0]  o_prod
);

    localparam int HW = sbo_pkg::HALF_W;

    logic [sbo_pkg::ELEM_W-1:0] r_elem;
    logic [HW-1:0]              r_acc_lo;
    logic [HW-1:0]              r_acc_hi;
    logic [HW-1:0]              r_lo2;
    logic [HW-1:0]              r_cross2;
    logic [HW-1:0]              r_blo2;

    logic [2*HW-1:0] p_ll;
    logic [2*HW-1:0] p_lh;
    logic [2*HW-1:0] p_hl;
    logic [HW-1:0]   n_cross;
    logic [HW-1:0]   n_hi;

    // stage 1: low half only needs low halves
    assign p_ll    = r_acc_lo * i_factor[HW-1:0];
    assign p_lh    = r_acc_lo * i_factor[2*HW-1:HW];
    assign n_cross = p_ll[2*HW-1:HW] + p_lh[HW-1:0];

    // stage 2: fold in the previous high half
    assign p_hl   = r_acc_hi * r_blo2;
    assign n_hi   = r_cross2 + p_hl[HW-1:0];
    assign o_prod = {n_hi, r_lo2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem   <= sbo_pkg::ELEM_BYTES_RST;
            r_acc_lo <= HW'(sbo_pkg::ELEM_BYTES_RST);
            r_acc_hi <= '0;
        end else if (i_ctl.cfg_we) begin
            r_elem   <= i_cfg_data;
            r_acc_lo <= HW'(i_cfg_data);
            r_acc_hi <= '0;
        end else begin
            if (i_ctl.s1_go) begin
                r_acc_lo <= i_ctl.s1_last ? HW'(r_elem) : p_ll[HW-1:0];
            end
            if (i_ctl.s2_go) begin
                r_acc_hi <= i_ctl.s2_last ? '0 : n_hi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_go) begin
            r_lo2    <= p_ll[HW-1:0];
            r_cross2 <= n_cross;
            r_blo2   <= i_factor[HW-1:0];
        end
    end

endmodule

// ===== sim/selection_block_overlap_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// selection_block_overlap_tb
// Self-checking bench for the selection/block overlap pipeline. A local
// predictor tracks the running overlap, bound and payload state and checks
// every result transfer field by field. Directed corner cases come first,
// then constrained-looking random selections under several flow-control mixes.
// ----------------------------------------------------------------------------
module selection_block_overlap_tb;

    localparam int                DATA_W         = sbo_pkg::DATA_W;
    localparam int                ELEM_W         = sbo_pkg::ELEM_W;
    localparam int                DIM_IDX_W      = sbo_pkg::DIM_IDX_W;
    localparam int                MAX_DIMS_DEF   = sbo_pkg::MAX_DIMS_DEF;
    localparam logic [ELEM_W-1:0] ELEM_BYTES_RST = sbo_pkg::ELEM_BYTES_RST;

    localparam int                WDOG_LIMIT  = 3000;  // cycles with no transfer at all
    localparam int                HOLD_CYCLES = 400;   // long receiver back-pressure
    localparam int                DRAIN_WAIT  = 8;     // > pipeline latency
    localparam int                MAX_REPORTS = 50;
    localparam logic [DATA_W-1:0] ALL_ONES    = '1;

    // One dimension of a selection, as offered on the input channel
    typedef struct {
        logic [DATA_W-1:0] sel_start;
        logic [DATA_W-1:0] sel_count;
        logic [DATA_W-1:0] block_size;
        logic [DATA_W-1:0] global_size;
        logic [DATA_W-1:0] block_offset;
        logic              last_dim;
    } t_dim_item;

    // Expected content of one result transfer
    typedef struct {
        logic [DATA_W-1:0]    part_size;
        logic [DATA_W-1:0]    off_in_block;
        logic [DATA_W-1:0]    off_in_sel;
        logic [DIM_IDX_W-1:0] dim_index;
        logic                 is_last;
        logic                 block_useful;
        logic                 out_of_bound;
        logic [DATA_W-1:0]    payload_bytes;
    } t_overlap_result;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [ELEM_W-1:0]       i_cfg_wr_data = '0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic [DATA_W-1:0]       i_sel_start = '0;
    logic [DATA_W-1:0]       i_sel_count = '0;
    logic [DATA_W-1:0]       i_block_size = '0;
    logic [DATA_W-1:0]       i_global_size = '0;
    logic [DATA_W-1:0]       i_block_offset = '0;
    logic                    i_last_dim = 1'b0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic [DATA_W-1:0]       o_part_size;
    logic [DATA_W-1:0]       o_part_offset_in_block;
    logic [DATA_W-1:0]       o_part_offset_in_selection;
    logic [DIM_IDX_W-1:0]    o_dim_index;
    logic                    o_is_last;
    logic                    o_block_useful;
    logic                    o_out_of_bound;
    logic [DATA_W-1:0]       o_payload_bytes;

    selection_block_overlap #(
        .MAX_DIMS(MAX_DIMS_DEF)
    ) dut (
        .i_clk                      (i_clk),
        .i_rst_n                    (i_rst_n),
        .i_cfg_wr_en                (i_cfg_wr_en),
        .i_cfg_wr_data              (i_cfg_wr_data),
        .i_valid                    (i_valid),
        .o_ready                    (o_ready),
        .i_sel_start                (i_sel_start),
        .i_sel_count                (i_sel_count),
        .i_block_size               (i_block_size),
        .i_global_size              (i_global_size),
        .i_block_offset             (i_block_offset),
        .i_last_dim                 (i_last_dim),
        .o_valid                    (o_valid),
        .i_ready                    (i_ready),
        .o_part_size                (o_part_size),
        .o_part_offset_in_block     (o_part_offset_in_block),
        .o_part_offset_in_selection (o_part_offset_in_selection),
        .o_dim_index                (o_dim_index),
        .o_is_last                  (o_is_last),
        .o_block_useful             (o_block_useful),
        .o_out_of_bound             (o_out_of_bound),
        .o_payload_bytes            (o_payload_bytes)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_dim_item       dims_pending[$];   // not yet offered to the DUT
    t_overlap_result results_due[$];    // predicted, not yet seen on the output
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    bit              pressure_req   = 1'b0;  // set once by the sequencer
    bit              pressure_taken = 1'b0;
    int              hold_left      = 0;
    int              errors         = 0;
    int              quiet_cycles   = 0;

    // Predictor copy of the block's configuration and running state
    logic [ELEM_W-1:0] elem_bytes_cfg = ELEM_BYTES_RST;
    logic              run_useful     = 1'b1;
    logic              run_oob        = 1'b0;
    logic [DATA_W-1:0] run_payload    = DATA_W'(ELEM_BYTES_RST);
    int                run_dim        = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor: all end points and compares are done 65 bits wide so that
    // a selection or block reaching past 2^64 never wraps.
    // ------------------------------------------------------------------------
    function automatic t_overlap_result predict_overlap(t_dim_item d);
        t_overlap_result   r;
        logic [DATA_W:0]   sel_end, blk_end, w_start, w_off, w_glob;
        logic [DATA_W-1:0] size, off_blk, off_sel, prod;
        logic              dim_hit, dim_oob;

        w_start = {1'b0, d.sel_start};
        w_off   = {1'b0, d.block_offset};
        w_glob  = {1'b0, d.global_size};
        sel_end = w_start + {1'b0, d.sel_count};
        blk_end = w_off + {1'b0, d.block_size};

        dim_oob = (d.sel_count > d.global_size) || (d.sel_start > d.global_size) ||
                  (sel_end > w_glob);
        dim_hit = (d.block_offset >= d.sel_start && w_off < sel_end) ||
                  (d.block_offset < d.sel_start && sel_end < blk_end) ||
                  (w_start < blk_end && !(sel_end < blk_end));

        size    = '0;
        off_blk = '0;
        off_sel = '0;
        if (d.sel_start >= d.block_offset) begin
            // selection starts inside or after the block
            if (w_start < blk_end) begin
                size    = (blk_end < sel_end) ? blk_end[DATA_W-1:0] - d.sel_start
                                              : d.sel_count;
                off_blk = d.sel_start - d.block_offset;
            end
        end else begin
            // block starts inside or after the selection
            if (blk_end < sel_end)
                size = d.block_size;
            else if (w_off < sel_end)
                size = d.sel_count - (d.block_offset - d.sel_start);
            off_sel = d.block_offset - d.sel_start;
        end
        if (size == '0) begin
            off_blk = '0;
            off_sel = '0;
        end

        prod = run_payload * d.block_size;   // wraps mod 2^64

        r.part_size     = size;
        r.off_in_block  = off_blk;
        r.off_in_sel    = off_sel;
        r.dim_index     = DIM_IDX_W'(run_dim);
        r.is_last       = d.last_dim;
        r.block_useful  = run_useful && dim_hit;
        r.out_of_bound  = run_oob || dim_oob;
        r.payload_bytes = prod;

        // last dimension closes the selection
        if (d.last_dim) begin
            run_useful  = 1'b1;
            run_oob     = 1'b0;
            run_payload = DATA_W'(elem_bytes_cfg);
            run_dim     = 0;
        end else begin
            run_useful  = r.block_useful;
            run_oob     = r.out_of_bound;
            run_payload = prod;
            run_dim     = (run_dim + 1 >= MAX_DIMS_DEF) ? 0 : run_dim + 1;
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: takes the next pending dimension once the current one has
    // transferred (or none is offered), idling at the phase's rate.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        t_dim_item d;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (dims_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                d = dims_pending.pop_front();
                i_sel_start    <= d.sel_start;
                i_sel_count    <= d.sel_count;
                i_block_size   <= d.block_size;
                i_global_size  <= d.global_size;
                i_block_offset <= d.block_offset;
                i_last_dim     <= d.last_dim;
                i_valid        <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request so that the
    // pipeline fills and pushes back on the sender.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (pressure_req && !pressure_taken) begin
            pressure_taken <= 1'b1;
            hold_left      <= HOLD_CYCLES;
            i_ready        <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check the output transfer first, then predict the input
    // transfer of the same edge. Also the no-progress watchdog.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_overlap_result want;
        t_dim_item       seen;
        logic            moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_valid && i_ready) begin
                moved = 1'b1;
                if (results_due.size() == 0) begin
                    if (errors < MAX_REPORTS)
                        $error("result transfer with no expected result pending");
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    check_field("part_size", want.part_size, o_part_size);
                    check_field("part_offset_in_block", want.off_in_block,
                                o_part_offset_in_block);
                    check_field("part_offset_in_selection", want.off_in_sel,
                                o_part_offset_in_selection);
                    check_field("dim_index", DATA_W'(want.dim_index), DATA_W'(o_dim_index));
                    check_field("is_last", DATA_W'(want.is_last), DATA_W'(o_is_last));
                    check_field("block_useful", DATA_W'(want.block_useful),
                                DATA_W'(o_block_useful));
                    check_field("out_of_bound", DATA_W'(want.out_of_bound),
                                DATA_W'(o_out_of_bound));
                    check_field("payload_bytes", want.payload_bytes, o_payload_bytes);
                end
            end
            if (i_valid && o_ready) begin
                moved             = 1'b1;
                seen.sel_start    = i_sel_start;
                seen.sel_count    = i_sel_count;
                seen.block_size   = i_block_size;
                seen.global_size  = i_global_size;
                seen.block_offset = i_block_offset;
                seen.last_dim     = i_last_dim;
                results_due.push_back(predict_overlap(seen));
            end
            if (moved) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WDOG_LIMIT) begin
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mix of tiny, mid, huge, near-max and power-of-two values
    function automatic logic [DATA_W-1:0] pick_extent();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return DATA_W'($urandom_range(0, 48));
            4, 5:       return DATA_W'($urandom_range(0, 1 << 20));
            6:          return rand64();
            7:          return ~DATA_W'($urandom_range(0, 8));
            8:          return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            default:    return rand64() >> $urandom_range(1, DATA_W - 1);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_upto(logic [DATA_W-1:0] bound);
        if (&bound)
            return rand64();
        return rand64() % (bound + 1);
    endfunction

    // Mostly a consistent dimension (block and selection inside the global
    // extent), sometimes one past the edge, sometimes pure noise.
    function automatic t_dim_item gen_dim(logic last);
        t_dim_item d;
        d.last_dim = last;
        if ($urandom_range(0, 4) == 0) begin
            d.sel_start    = pick_extent();
            d.sel_count    = pick_extent();
            d.block_size   = pick_extent();
            d.global_size  = pick_extent();
            d.block_offset = pick_extent();
        end else begin
            d.global_size  = pick_extent();
            d.block_offset = rand_upto(d.global_size);
            d.block_size   = rand_upto(d.global_size - d.block_offset);
            d.sel_start    = rand_upto(d.global_size);
            d.sel_count    = rand_upto(d.global_size - d.sel_start);
            if ($urandom_range(0, 9) == 0)
                d.sel_count = d.sel_count + 1;
        end
        return d;
    endfunction

    task automatic push_dim(logic [DATA_W-1:0] s, logic [DATA_W-1:0] c,
                            logic [DATA_W-1:0] l, logic [DATA_W-1:0] g,
                            logic [DATA_W-1:0] o, logic last);
        t_dim_item d;
        d.sel_start    = s;
        d.sel_count    = c;
        d.block_size   = l;
        d.global_size  = g;
        d.block_offset = o;
        d.last_dim     = last;
        dims_pending.push_back(d);
    endtask

    // Whole selections of 1..4 dimensions, now and then a long one of 5..20 that
    // can run the dimension counter past its wrap. The last selection may be
    // cut off, leaving running state across the next register write.
    task automatic queue_selections(int n_dims);
        int queued;
        int span;
        queued = 0;
        while (queued < n_dims) begin
            span = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            for (int k = 0; k < span && queued < n_dims; k++) begin
                dims_pending.push_back(gen_dim(k == span - 1));
                queued++;
            end
        end
    endtask

    // Wait until nothing is queued, offered or outstanding
    task automatic wait_drained();
        @(negedge i_clk);
        while (dims_pending.size() != 0 || i_valid || results_due.size() != 0)
            @(negedge i_clk);
    endtask

    // Register write; the block is idle, so the predictor follows at once
    task automatic write_elem_bytes(logic [ELEM_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en    <= 1'b0;
        elem_bytes_cfg = value;
        run_payload    = DATA_W'(value);
        @(negedge i_clk);
    endtask

    task automatic run_phase(logic [ELEM_W-1:0] elem, int n_dims, int idle_pct,
                             int stall_pct, bit hold);
        wait_drained();
        write_elem_bytes(elem);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        queue_selections(n_dims);
        if (hold)
            pressure_req = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed pass at the reset element size, no idling. Eighteen open
        // dimensions wrap the dimension index before the selection closes.
        push_dim(0, 0, 0, 0, 0, 1'b0);               // everything zero
        push_dim(10, 5, 4, 100, 12, 1'b0);           // block starts inside, runs past end
        push_dim(12, 2, 10, 100, 10, 1'b0);          // selection inside block
        push_dim(5, 10, 3, 100, 8, 1'b0);            // block inside selection
        push_dim(0, 5, 4, 100, 5, 1'b0);             // selection ends at block start
        push_dim(20, 3, 4, 100, 10, 1'b0);           // selection after block
        push_dim(10, 0, 4, 100, 10, 1'b0);           // zero count at block start
        push_dim(10, 5, 0, 100, 12, 1'b0);           // zero block size
        push_dim(0, 200, 4, 100, 0, 1'b0);           // count beyond global size
        push_dim(150, 1, 4, 100, 0, 1'b0);           // start beyond global size
        push_dim(95, 10, 4, 100, 96, 1'b0);          // end beyond global size
        push_dim(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b0);
        push_dim(0, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b0);
        push_dim(ALL_ONES, 1, 1, ALL_ONES, ALL_ONES, 1'b0);
        push_dim(0, 3, DATA_W'(1) << (DATA_W - 1), 10, 0, 1'b0);  // product overflow
        push_dim(1, 1, 2, 4, 0, 1'b0);
        push_dim(0, 1, 3, 1, 0, 1'b0);
        push_dim(7, 7, 7, 7, 0, 1'b0);
        push_dim(2, 2, 2, 8, 1, 1'b1);               // closes the long selection
        push_dim(3, 4, 5, 16, 2, 1'b1);              // one-dimension selection

        // Random phases across register settings and flow-control mixes
        run_phase(ELEM_W'(16), 150, 0, 0, 1'b0);
        run_phase('1, 150, 64, 0, 1'b0);              // register maximum
        run_phase('0, 150, 0, 64, 1'b0);              // zero element size
        run_phase(ELEM_W'($urandom_range(1, 16)), 150, 37, 37, 1'b0);
        run_phase(ELEM_W'(1), 150, 0, 0, 1'b1);       // long receiver hold-off
        run_phase(ELEM_W'($urandom_range(0, 31)), 150, 37, 37, 1'b0);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0 && results_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sbo_pkg.sv
hw/rtl/sbo_cmp.sv
hw/rtl/sbo_part.sv
hw/rtl/sbo_prod.sv
hw/rtl/selection_block_overlap.sv
sim/selection_block_overlap_tb.sv
